// File: sv/dhwd_pkg.sv
package dhwd_pkg;

    localparam int WORD_W      = 16;
    localparam int CFG_W       = 14;
    localparam int LIT_W       = 11;
    localparam int CODE_W      = 15;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_ZEROS   = 6;

    localparam logic [CFG_W-1:0] MAX_SAMPLES_RESET = 14'd9600;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CODE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Delta selected by the number of zeros before a code's closing one
    localparam logic [WORD_W-1:0] DELTA_TABLE [0:MAX_ZEROS] = '{
        16'h0000, 16'hffff, 16'h0001, 16'hfffe, 16'h0002, 16'hfffd, 16'h0003
    };

    // Classified word: literal value, or the code bits above the padding bit
    typedef struct packed {
        logic              literal;
        logic              first;
        logic [CODE_W-1:0] data;
    } entry_t;

endpackage

// File: sv/delta_huffman_word_decoder_unit.sv
// Delta/Huffman word decoder for one channel of packed sample words.
// Input channel (in_valid/in_ready): one 16-bit word plus first_of_channel
// per transaction. A word with bit 15 clear is a literal 11-bit sample; a
// word with bit 15 set holds coded deltas above a padding bit.
// Output channel (out_valid/out_ready): one result per transaction, with
// sample, status (ok, bad code, overflow) and last_of_word on the final
// result of each word. Ignored words (halted channel, padding only) give none.
// Configuration: cfg_write_en/cfg_write_data load max_samples;
// write it only while the block is idle.
// A literal passes through the queue, the work registers and the output register.
// Throughput: while the output is not stalled, the back end retires one result
// per cycle; literals stream at one per cycle.
// A two-entry queue sits between the front classifier and the back end, so
// the input keeps accepting while the output is stalled until it fills.
// Reset clears the reference value, sample count, halt flag and queue, and
// loads max_samples with 9600. A stalled receiver holds the output result.
module delta_huffman_word_decoder_unit
#(
    parameter int COUNT_WIDTH = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [dhwd_pkg::CFG_W-1:0]    cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dhwd_pkg::WORD_W-1:0]   word,
    input  logic                          first_of_channel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dhwd_pkg::WORD_W-1:0]   sample,
    output logic [dhwd_pkg::STATUS_W-1:0] status,
    output logic                          last_of_word
);

    logic [dhwd_pkg::CFG_W-1:0] max_samples_reg;
    dhwd_pkg::entry_t           front_entry;
    dhwd_pkg::entry_t           q_head;
    logic                       q_full, q_not_empty, q_pop;

    // Hold the sample limit; reload on every configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_samples_reg <= dhwd_pkg::MAX_SAMPLES_RESET;
        end
        else if (cfg_write_en)
        begin
            max_samples_reg <= cfg_write_data;
        end
    end

    // Classify the word as it arrives: literal value or code bits
    dhwd_front u_front
    (
        .word             (word),
        .first_of_channel (first_of_channel),
        .entry            (front_entry)
    );

    assign in_ready = ~q_full;

    dhwd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Apply channel state and retire one result per cycle while the output is not stalled
    dhwd_back
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_samples  (max_samples_reg),
        .q_valid      (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .status       (status),
        .last_of_word (last_of_word)
    );

endmodule

// File: sv/dhwd_front.sv
module dhwd_front
(
    input  logic [dhwd_pkg::WORD_W-1:0] word,
    input  logic                        first_of_channel,
    output dhwd_pkg::entry_t            entry
);

    logic [3:0]                  pad_pos;
    logic [dhwd_pkg::WORD_W-1:0] above_pad;

    // Locate the padding bit: the lowest set bit of the word
    always_comb
    begin
        pad_pos = 4'd0;
        for (int i = dhwd_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                pad_pos = 4'(i);
            end
        end
    end

    assign above_pad = (word >> pad_pos) >> 1;

    always_comb
    begin
        entry.literal = ~word[dhwd_pkg::WORD_W-1];
        entry.first   = first_of_channel;
        if (entry.literal)
        begin
            entry.data = {{(dhwd_pkg::CODE_W - dhwd_pkg::LIT_W){1'b0}},
                          word[dhwd_pkg::LIT_W-1:0]};
        end
        else
        begin
            entry.data = above_pad[dhwd_pkg::CODE_W-1:0];
        end
    end

endmodule

// File: sv/dhwd_queue.sv
module dhwd_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dhwd_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output dhwd_pkg::entry_t head
);

    localparam int PTR_W = $clog2(dhwd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dhwd_pkg::QUEUE_DEPTH + 1);

    dhwd_pkg::entry_t   slots_reg [0:dhwd_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(dhwd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(dhwd_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(dhwd_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: sv/dhwd_back.sv
module dhwd_back
#(
    parameter int COUNT_WIDTH = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dhwd_pkg::CFG_W-1:0]    max_samples,
    input  logic                          q_valid,
    input  dhwd_pkg::entry_t              q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dhwd_pkg::WORD_W-1:0]   sample,
    output logic [dhwd_pkg::STATUS_W-1:0] status,
    output logic                          last_of_word
);

    localparam int CMP_W = (COUNT_WIDTH > dhwd_pkg::CFG_W) ? COUNT_WIDTH : dhwd_pkg::CFG_W;

    // Channel state
    logic [dhwd_pkg::WORD_W-1:0]   ref_reg, ref_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic                          halted_reg, halted_next;

    // Word in progress
    logic                          work_valid_reg;
    logic                          lit_reg;
    logic                          first_reg;
    logic                          first_step_reg;
    logic [dhwd_pkg::CODE_W-1:0]   code_reg, code_next;

    // Output register
    logic                          out_valid_reg;
    logic [dhwd_pkg::WORD_W-1:0]   sample_reg, sample_next;
    logic [dhwd_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          last_reg, last_next;

    logic                          slot_free, step, emit, done, take, clear_now;
    logic [dhwd_pkg::WORD_W-1:0]   ref_eff;
    logic [COUNT_WIDTH-1:0]        count_eff, count_inc;
    logic                          halted_eff;
    logic [3:0]                    low_pos;
    logic [dhwd_pkg::CODE_W-1:0]   code_shifted;

    assign slot_free = ~out_valid_reg | out_ready;
    assign step      = work_valid_reg & slot_free;
    assign take      = q_valid & (~work_valid_reg | (step & done));
    assign q_pop     = take;

    assign clear_now  = first_reg & first_step_reg;
    assign ref_eff    = clear_now ? '0 : ref_reg;
    assign count_eff  = clear_now ? '0 : count_reg;
    assign halted_eff = clear_now ? 1'b0 : halted_reg;
    assign count_inc  = (count_eff == '1) ? count_eff : count_eff + COUNT_WIDTH'(1);

    // Lowest set bit of the remaining code bits closes the next code
    always_comb
    begin
        low_pos = 4'd0;
        for (int i = dhwd_pkg::CODE_W - 1; i >= 0; i--)
        begin
            if (code_reg[i])
            begin
                low_pos = 4'(i);
            end
        end
    end

    assign code_shifted = (code_reg >> low_pos) >> 1;

    always_comb
    begin
        ref_next    = ref_eff;
        count_next  = count_eff;
        halted_next = halted_eff;
        code_next   = code_reg;
        sample_next = '0;
        status_next = dhwd_pkg::STATUS_OK;
        last_next   = 1'b1;
        emit        = 1'b0;
        done        = 1'b1;
        if (first_step_reg && halted_eff)
        begin
            // drop the word
        end
        else if (first_step_reg && (CMP_W'(count_eff) > CMP_W'(max_samples)))
        begin
            emit        = 1'b1;
            status_next = dhwd_pkg::STATUS_OVERFLOW;
            halted_next = 1'b1;
        end
        else if (first_step_reg && lit_reg)
        begin
            emit        = 1'b1;
            ref_next    = dhwd_pkg::WORD_W'(code_reg[dhwd_pkg::LIT_W-1:0]);
            sample_next = ref_next;
            count_next  = count_inc;
        end
        else if (code_reg == '0)
        begin
            // padding only: nothing left to decode
        end
        else if (low_pos > 4'(dhwd_pkg::MAX_ZEROS))
        begin
            emit        = 1'b1;
            status_next = dhwd_pkg::STATUS_BAD_CODE;
            halted_next = 1'b1;
        end
        else
        begin
            emit        = 1'b1;
            ref_next    = ref_eff + dhwd_pkg::DELTA_TABLE[low_pos[2:0]];
            sample_next = ref_next;
            count_next  = count_inc;
            code_next   = code_shifted;
            last_next   = (code_shifted == '0);
            done        = last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= '0;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
            work_valid_reg <= 1'b0;
            first_step_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                ref_reg    <= ref_next;
                count_reg  <= count_next;
                halted_reg <= halted_next;
            end
            if (take)
            begin
                work_valid_reg <= 1'b1;
                first_step_reg <= 1'b1;
            end
            else if (step)
            begin
                work_valid_reg <= ~done;
                first_step_reg <= 1'b0;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            lit_reg   <= q_head.literal;
            first_reg <= q_head.first;
            code_reg  <= q_head.data;
        end
        else if (step)
        begin
            code_reg <= code_next;
        end
        if (step && emit)
        begin
            sample_reg <= sample_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign status       = status_reg;
    assign last_of_word = last_reg;

endmodule
